// File: hdl/btum_pkg.sv
package btum_pkg;

    localparam int TIME_W  = 32;
    localparam int CNT_W   = $clog2(TIME_W);
    localparam int WIN_W   = 11;
    localparam int PCT_W   = 7;
    localparam int SPAN_W  = 21;
    localparam int NUM_W   = SPAN_W + PCT_W;
    localparam int CMP_W   = (TIME_W > SPAN_W) ? TIME_W : SPAN_W;

    localparam logic [WIN_W-1:0]  WIN_MIN   = 11'd100;
    localparam logic [WIN_W-1:0]  WIN_MAX   = 11'd2000;
    localparam logic [WIN_W-1:0]  WIN_RESET = 11'd1000;
    localparam logic [SPAN_W-1:0] US_PER_MS = 21'd1000;
    localparam logic [PCT_W-1:0]  PCT_MAX   = 7'd100;

    localparam logic [1:0] KIND_START  = 2'd0;
    localparam logic [1:0] KIND_END    = 2'd1;
    localparam logic [1:0] KIND_UPDATE = 2'd2;

endpackage

// File: hdl/busy_time_utilization_monitor_top.sv
// Busy time utilization monitor.
// Input channel (in_valid, in_stall, kind, time_us, time_ms) carries one request per
// task start, task end or window update. Output channel (out_valid, out_stall,
// cpu_percent, window_closed) returns exactly one result per request, carrying the
// percent of the last closed window and a flag set when this request closed one.
// The user must write the window length through cfg_we/cfg_wdata only while the
// block is idle; the block does not enforce this. Writes are clamped to 100..2000 ms.
// One request is processed at a time. A start, an update that seeds the window or an
// ignored request goes straight to the final state. A task end runs a bit-serial subtract
// and add over the 32 timestamp bits. An update with a running window runs a bit-serial
// elapsed-time compare over the 32 timestamp bits and ends there when the window stays open;
// a window close adds the span multiply, a saturation check and a 7-step restoring
// divide, and skips the divide when the percent saturates.
// The next request is accepted at the edge where the previous result can first be
// taken, so no new request is taken before the previous one is through.
// While the output register holds an untaken result the block still accepts the next
// request; it waits in its final state until out_stall drops before loading a new
// result. Reset clears all accumulated state, sets the window to 1000 ms and leaves
// the output channel empty.
module busy_time_utilization_monitor_top
    import btum_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        kind,
    input  logic [TIME_W-1:0] time_us,
    input  logic [TIME_W-1:0] time_ms,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [PCT_W-1:0]  cpu_percent,
    output logic              window_closed,
    input  logic              cfg_we,
    input  logic [WIN_W-1:0]  cfg_wdata
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_ADD      = 3'd1;
    localparam logic [2:0] S_CMP      = 3'd2;
    localparam logic [2:0] S_SPAN     = 3'd3;
    localparam logic [2:0] S_DIV_INIT = 3'd4;
    localparam logic [2:0] S_DIV      = 3'd5;
    localparam logic [2:0] S_CLOSE    = 3'd6;
    localparam logic [2:0] S_DONE     = 3'd7;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TIME_W - 1);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(PCT_W - 1);

    logic [2:0]           state_reg, state_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [WIN_W-1:0]     window_reg, window_next;
    logic [TIME_W-1:0]    busy_reg, busy_next;
    logic [TIME_W-1:0]    wstart_reg, wstart_next;
    logic [TIME_W-1:0]    tstart_reg, tstart_next;
    logic                 active_reg, active_next;
    logic [PCT_W-1:0]     pct_reg, pct_next;
    logic [TIME_W-1:0]    tus_reg, tus_next;
    logic [TIME_W-1:0]    tms_reg, tms_next;
    logic [TIME_W-1:0]    win_sh_reg, win_sh_next;
    logic                 c0_reg, c0_next;
    logic                 c1_reg, c1_next;
    logic                 closed_reg, closed_next;
    logic [SPAN_W-1:0]    span_reg, span_next;
    logic [NUM_W-1:0]     rem_reg, rem_next;
    logic [NUM_W-2:0]     div_reg, div_next;
    logic [PCT_W-1:0]     quo_reg, quo_next;
    logic                 out_valid_reg, out_valid_next;
    logic [PCT_W-1:0]     out_pct_reg, out_pct_next;
    logic                 out_closed_reg, out_closed_next;

    logic                 in_take;
    logic                 out_free;
    logic                 d_bit;
    logic                 r_bit;
    logic                 b0_out;
    logic                 b1_out;
    logic [WIN_W-1:0]     cfg_clamped;
    logic [CMP_W-1:0]     busy_ext;
    logic [CMP_W-1:0]     span_ext;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    assign out_valid     = out_valid_reg;
    assign cpu_percent   = out_pct_reg;
    assign window_closed = out_closed_reg;

    assign busy_ext = CMP_W'(busy_reg);
    assign span_ext = CMP_W'(span_reg);

    always_comb
    begin
        if (cfg_wdata < WIN_MIN)
        begin
            cfg_clamped = WIN_MIN;
        end
        else if (cfg_wdata > WIN_MAX)
        begin
            cfg_clamped = WIN_MAX;
        end
        else
        begin
            cfg_clamped = cfg_wdata;
        end
    end

    // Bit-serial datapath, least significant bit first. In the task end pass the
    // first chain forms t_us - task_start and the second adds it into busy time.
    // In the update pass the first chain forms t_ms - window_start and the second
    // subtracts the window length; its final borrow is the compare result.
    always_comb
    begin
        if (state_reg == S_ADD)
        begin
            d_bit  = tus_reg[0] ^ tstart_reg[0] ^ c0_reg;
            b0_out = (!tus_reg[0] && (tstart_reg[0] || c0_reg)) || (tstart_reg[0] && c0_reg);
            r_bit  = busy_reg[0] ^ d_bit ^ c1_reg;
            b1_out = (busy_reg[0] && d_bit) || (busy_reg[0] && c1_reg) || (d_bit && c1_reg);
        end
        else
        begin
            d_bit  = tms_reg[0] ^ wstart_reg[0] ^ c0_reg;
            b0_out = (!tms_reg[0] && (wstart_reg[0] || c0_reg)) || (wstart_reg[0] && c0_reg);
            r_bit  = d_bit ^ win_sh_reg[0] ^ c1_reg;
            b1_out = (!d_bit && (win_sh_reg[0] || c1_reg)) || (win_sh_reg[0] && c1_reg);
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        window_next     = window_reg;
        busy_next       = busy_reg;
        wstart_next     = wstart_reg;
        tstart_next     = tstart_reg;
        active_next     = active_reg;
        pct_next        = pct_reg;
        tus_next        = tus_reg;
        tms_next        = tms_reg;
        win_sh_next     = win_sh_reg;
        c0_next         = c0_reg;
        c1_next         = c1_reg;
        closed_next     = closed_reg;
        span_next       = span_reg;
        rem_next        = rem_reg;
        div_next        = div_reg;
        quo_next        = quo_reg;
        out_valid_next  = out_valid_reg;
        out_pct_next    = out_pct_reg;
        out_closed_next = out_closed_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_we)
        begin
            window_next = cfg_clamped;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    tus_next    = time_us;
                    tms_next    = time_ms;
                    win_sh_next = TIME_W'(window_reg);
                    c0_next     = 1'b0;
                    c1_next     = 1'b0;
                    cnt_next    = '0;
                    closed_next = 1'b0;
                    state_next  = S_DONE;
                    case (kind)
                        KIND_START:
                        begin
                            if (!active_reg)
                            begin
                                tstart_next = time_us;
                                active_next = 1'b1;
                            end
                        end
                        KIND_END:
                        begin
                            if (active_reg)
                            begin
                                state_next = S_ADD;
                            end
                        end
                        KIND_UPDATE:
                        begin
                            // A zero window start means no window is running yet.
                            if (wstart_reg == '0)
                            begin
                                wstart_next = time_ms;
                            end
                            else
                            begin
                                state_next = S_CMP;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_ADD:
            begin
                busy_next   = {r_bit, busy_reg[TIME_W-1:1]};
                tstart_next = {tstart_reg[0], tstart_reg[TIME_W-1:1]};
                tus_next    = {tus_reg[0], tus_reg[TIME_W-1:1]};
                c0_next     = b0_out;
                c1_next     = b1_out;
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    active_next = 1'b0;
                    state_next  = S_DONE;
                end
            end
            S_CMP:
            begin
                // Both timestamp registers rotate, so they hold their values again at the end.
                tms_next    = {tms_reg[0], tms_reg[TIME_W-1:1]};
                wstart_next = {wstart_reg[0], wstart_reg[TIME_W-1:1]};
                win_sh_next = {1'b0, win_sh_reg[TIME_W-1:1]};
                c0_next     = b0_out;
                c1_next     = b1_out;
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = b1_out ? S_DONE : S_SPAN;
                end
            end
            S_SPAN:
            begin
                span_next  = SPAN_W'(SPAN_W'(window_reg) * US_PER_MS);
                state_next = S_DIV_INIT;
            end
            S_DIV_INIT:
            begin
                rem_next = NUM_W'(busy_ext[SPAN_W-1:0]) * NUM_W'(PCT_MAX);
                div_next = {span_reg, {(PCT_W-1){1'b0}}};
                quo_next = '0;
                cnt_next = DIV_LAST;
                if (busy_ext >= span_ext)
                begin
                    quo_next   = PCT_MAX;
                    state_next = S_CLOSE;
                end
                else
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (rem_reg >= {1'b0, div_reg})
                begin
                    rem_next = rem_reg - {1'b0, div_reg};
                    quo_next = {quo_reg[PCT_W-2:0], 1'b1};
                end
                else
                begin
                    quo_next = {quo_reg[PCT_W-2:0], 1'b0};
                end
                div_next = {1'b0, div_reg[NUM_W-2:1]};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = S_CLOSE;
                end
            end
            S_CLOSE:
            begin
                pct_next    = quo_reg;
                busy_next   = '0;
                wstart_next = tms_reg;
                closed_next = 1'b1;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_pct_next    = pct_reg;
                    out_closed_next = closed_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            window_reg    <= WIN_RESET;
            busy_reg      <= '0;
            wstart_reg    <= '0;
            tstart_reg    <= '0;
            active_reg    <= 1'b0;
            pct_reg       <= '0;
            c0_reg        <= 1'b0;
            c1_reg        <= 1'b0;
            closed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            window_reg    <= window_next;
            busy_reg      <= busy_next;
            wstart_reg    <= wstart_next;
            tstart_reg    <= tstart_next;
            active_reg    <= active_next;
            pct_reg       <= pct_next;
            c0_reg        <= c0_next;
            c1_reg        <= c1_next;
            closed_reg    <= closed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tus_reg        <= tus_next;
        tms_reg        <= tms_next;
        win_sh_reg     <= win_sh_next;
        span_reg       <= span_next;
        rem_reg        <= rem_next;
        div_reg        <= div_next;
        quo_reg        <= quo_next;
        out_pct_reg    <= out_pct_next;
        out_closed_reg <= out_closed_next;
    end

    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        pct_reg <= PCT_MAX)
        else $error("stored percent above saturation limit");

    a_window_range: assert property (@(posedge clk) disable iff (!rst_n)
        window_reg >= WIN_MIN && window_reg <= WIN_MAX)
        else $error("window length outside clamp range");

    a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLOSE |=> busy_reg == '0 && closed_reg && state_reg == S_DONE)
        else $error("window close did not clear busy time");

    a_end_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ADD && cnt_reg == CNT_LAST) |=> !active_reg && state_reg == S_DONE)
        else $error("task end pass did not stop timing");

    a_result_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_free) |=> out_valid_reg && out_closed_reg == $past(closed_reg))
        else $error("result not loaded with close flag");

endmodule

// File: tb/btum_checker.sv
module btum_checker
    import btum_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_stall,
    input  logic [1:0]        kind,
    input  logic [TIME_W-1:0] time_us,
    input  logic [TIME_W-1:0] time_ms,
    input  logic              out_valid,
    input  logic              out_stall,
    input  logic [PCT_W-1:0]  cpu_percent,
    input  logic              window_closed,
    input  logic              cfg_we,
    input  logic [WIN_W-1:0]  cfg_wdata,
    output int                fail_count,
    output int                pending
);

    typedef struct packed {
        logic [PCT_W-1:0] pct;
        logic             closed;
    } util_result_t;

    util_result_t      expected_util_q[$];
    int                mismatches;

    logic [WIN_W-1:0]  win_ms;
    logic [TIME_W-1:0] busy_us;
    logic [TIME_W-1:0] win_start_ms;
    logic [TIME_W-1:0] task_start_us;
    logic              timing;
    logic [PCT_W-1:0]  last_pct;

    // Advances the predicted monitor state by one request and returns its result.
    function automatic util_result_t step_monitor(input logic [1:0] k,
                                                  input logic [TIME_W-1:0] t_us,
                                                  input logic [TIME_W-1:0] t_ms);
        util_result_t      r;
        logic [63:0]       span;
        logic [TIME_W-1:0] elapsed;
        r.closed = 1'b0;
        if (k == KIND_START) begin
            if (!timing) begin
                task_start_us = t_us;
                timing = 1'b1;
            end
        end
        else if (k == KIND_END) begin
            if (timing) begin
                busy_us = busy_us + (t_us - task_start_us);
                timing = 1'b0;
            end
        end
        else if (k == KIND_UPDATE) begin
            elapsed = t_ms - win_start_ms;
            if (win_start_ms == '0) begin
                win_start_ms = t_ms;
            end
            else if (elapsed >= TIME_W'(win_ms)) begin
                span = 64'(win_ms) * 64'd1000;
                if (64'(busy_us) >= span)
                    last_pct = PCT_MAX;
                else
                    last_pct = PCT_W'((64'(busy_us) * 64'd100) / span);
                busy_us = '0;
                win_start_ms = t_ms;
                r.closed = 1'b1;
            end
        end
        r.pct = last_pct;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        util_result_t exp_r;
        if (!rst_n) begin
            win_ms = WIN_RESET;
            busy_us = '0;
            win_start_ms = '0;
            task_start_us = '0;
            timing = 1'b0;
            last_pct = '0;
            mismatches = 0;
            expected_util_q.delete();
            pending <= 0;
            fail_count <= 0;
        end
        else begin
            // The output side is checked first: a result leaving at this edge always
            // belongs to a request accepted at an earlier edge.
            if (out_valid && !out_stall) begin
                if (expected_util_q.size() == 0) begin
                    $error("unexpected result: cpu_percent %0d window_closed %0d",
                           cpu_percent, window_closed);
                    mismatches++;
                end
                else begin
                    exp_r = expected_util_q.pop_front();
                    if (cpu_percent !== exp_r.pct) begin
                        $error("cpu_percent: expected %0d, actual %0d", exp_r.pct, cpu_percent);
                        mismatches++;
                    end
                    if (window_closed !== exp_r.closed) begin
                        $error("window_closed: expected %0d, actual %0d",
                               exp_r.closed, window_closed);
                        mismatches++;
                    end
                end
            end
            if (cfg_we) begin
                if (cfg_wdata < WIN_MIN)
                    win_ms = WIN_MIN;
                else if (cfg_wdata > WIN_MAX)
                    win_ms = WIN_MAX;
                else
                    win_ms = cfg_wdata;
            end
            if (in_valid && !in_stall)
                expected_util_q.push_back(step_monitor(kind, time_us, time_ms));
            pending <= expected_util_q.size();
            fail_count <= mismatches;
        end
    end

endmodule

// File: tb/testbench.sv
module testbench;
    import btum_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 500000;
    localparam int NUM_PHASES = 8;
    localparam int PHASE_ITEMS = 75;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [1:0]        kind;
    logic [TIME_W-1:0] time_us;
    logic [TIME_W-1:0] time_ms;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [PCT_W-1:0]  cpu_percent;
    logic              window_closed;
    logic              cfg_we;
    logic [WIN_W-1:0]  cfg_wdata;

    int fail_count;
    int pending;
    int cycle_cnt = 0;
    int stall_left = 0;
    bit idle_on = 1'b1;

    always #5 clk = ~clk;

    busy_time_utilization_monitor_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .time_us      (time_us),
        .time_ms      (time_ms),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .cpu_percent  (cpu_percent),
        .window_closed(window_closed),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata)
    );

    btum_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .time_us      (time_us),
        .time_ms      (time_ms),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .cpu_percent  (cpu_percent),
        .window_closed(window_closed),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Receiver back-pressure in random bursts.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else if (idle_on && $urandom_range(0, 4) == 0)
        begin
            out_stall <= 1'b1;
            stall_left = $urandom_range(0, 2);
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    task automatic send_req(input logic [1:0] k, input logic [TIME_W-1:0] us,
                            input logic [TIME_W-1:0] ms);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        time_us <= us;
        time_ms <= ms;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Stops sending and waits until every predicted result has been taken.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [WIN_W-1:0] cfg_val;
        logic [1:0]       k;
        logic [63:0]      ms_full;
        longint unsigned  t_now;
        bit               task_open;
        int               win_now;
        int               pick;

        rst_n <= 1'b0;
        in_valid <= 1'b0;
        kind <= KIND_START;
        time_us <= '0;
        time_ms <= '0;
        cfg_we <= 1'b0;
        cfg_wdata <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, window at its reset length of 1000 ms.
        send_req(KIND_UPDATE, '0, '0);
        send_req(KIND_UPDATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_req(KIND_END, 32'd123, 32'd7);
        send_req(KIND_START, '0, '0);
        send_req(KIND_START, 32'd5000, 32'd1);
        send_req(KIND_END, 32'hFFFF_FFFF, 32'd2);
        send_req(KIND_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // Elapsed time wraps through zero: 999 ms stays open, 1000 ms closes saturated.
        send_req(KIND_UPDATE, '0, 32'd998);
        send_req(KIND_UPDATE, '0, 32'd999);
        send_req(KIND_START, 32'd16, '0);
        send_req(KIND_END, 32'd250016, '0);
        send_req(KIND_UPDATE, '0, 32'd1999);
        // This close restarts the window at zero, so the next update seeds it again.
        send_req(KIND_UPDATE, '0, '0);
        send_req(KIND_UPDATE, '0, 32'd5);
        send_req(KIND_START, 32'hFFFF_FF00, '0);
        send_req(KIND_END, 32'h0000_0100, '0);
        send_req(KIND_UPDATE, '0, 32'd1004);
        send_req(KIND_UPDATE, '0, 32'd1005);
        send_req(KIND_END, '0, '0);

        t_now = 64'h0000_0000_FFF0_0000;
        task_open = 1'b0;
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            drain();
            case (ph)
                0: cfg_val = '0;
                1: cfg_val = 11'h7FF;
                2: cfg_val = WIN_MIN - 11'd1;
                3: cfg_val = WIN_MAX + 11'd1;
                4: cfg_val = WIN_MIN;
                5: cfg_val = WIN_MAX;
                6: cfg_val = 11'd500;
                default: cfg_val = WIN_W'($urandom_range(0, 2047));
            endcase
            win_now = (cfg_val < WIN_MIN) ? int'(WIN_MIN) :
                      (cfg_val > WIN_MAX) ? int'(WIN_MAX) : int'(cfg_val);
            cfg_we <= 1'b1;
            cfg_wdata <= cfg_val;
            @(posedge clk);
            cfg_we <= 1'b0;

            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i % 25 == 0)
                    idle_on = (ph < NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
                pick = $urandom_range(0, 99);
                if (pick < 12)
                begin
                    send_req(2'($urandom_range(0, 3)), $urandom, $urandom);
                end
                else
                begin
                    if ($urandom_range(0, 3) == 0)
                        t_now += $urandom_range(0, 999);
                    else
                        t_now += $urandom_range(0, win_now * 250);
                    if (pick < 60)
                    begin
                        k = task_open ? KIND_END : KIND_START;
                        task_open = !task_open;
                    end
                    else
                    begin
                        k = KIND_UPDATE;
                    end
                    ms_full = t_now / 1000;
                    send_req(k, t_now[31:0], ms_full[31:0]);
                end
            end
        end

        idle_on = 1'b0;
        drain();
        repeat (60) @(posedge clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: sim.f
hdl/btum_pkg.sv
hdl/busy_time_utilization_monitor_top.sv
tb/btum_checker.sv
tb/testbench.sv
